// ===== rtl/dmtt_pkg.sv =====
// Shared types and constants for the direct-mapped transposition table.
// Used by dmtt_ctrl, dmtt_datapath and direct_mapped_transposition_table_core.
package dmtt_pkg;

    localparam int INDEX_BITS = 16;
    localparam int MOVE_BITS  = 16;
    localparam int KEY_BITS   = 64;
    localparam int SLOT_COUNT = 2 ** INDEX_BITS;

    localparam logic [4:0] SIZE_LOG2_RESET = 5'd16;

    localparam logic [1:0] ACT_PROBE = 2'd0;
    localparam logic [1:0] ACT_STORE = 2'd1;
    localparam logic [1:0] ACT_CLEAR = 2'd2;

    localparam logic signed [31:0] DEPTH_MIN = -32'sd32768;
    localparam logic signed [31:0] DEPTH_MAX = 32'sd32767;

    typedef struct packed {
        logic [1:0]          action;
        logic [63:0]         key;
        logic signed [31:0]  depth;
        logic signed [31:0]  score;
        logic [1:0]          bound;
        logic [15:0]         move;
    } req_t;

    typedef struct packed {
        logic                hit;
        logic signed [15:0]  hit_depth;
        logic signed [31:0]  hit_score;
        logic [1:0]          hit_bound;
        logic [15:0]         hit_move;
    } rsp_t;

    typedef struct packed {
        logic                  valid;
        logic [KEY_BITS-1:0]   key;
        logic signed [15:0]    depth;
        logic signed [31:0]    score;
        logic [1:0]            bound;
        logic [MOVE_BITS-1:0]  move;
    } entry_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_ACCESS
    } state_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic                   lookup;
        logic                   eval;
        logic                   clr_we;
        logic [INDEX_BITS-1:0]  clr_addr;
        logic                   cfg_we;
    } cmd_t;

endpackage

// ===== rtl/dmtt_ctrl.sv =====
// Controller state machine: request sequencing and the table clearing sweep.
// Depends on dmtt_pkg for the state, command and action codes.
module dmtt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic [1:0]         action,
    input  logic               cfg_write,
    output logic               busy,
    output dmtt_pkg::cmd_t     cmd
);

    dmtt_pkg::state_t                   state_reg, state_next;
    logic [dmtt_pkg::INDEX_BITS-1:0]    count_reg, count_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= dmtt_pkg::ST_CLEAR;
            count_reg <= '0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = count_reg;
        busy         = 1'b1;
        cmd          = '0;
        cmd.clr_addr = count_reg;
        cmd.cfg_we   = cfg_write;
        case (state_reg)
            dmtt_pkg::ST_CLEAR:
            begin
                cmd.clr_we = 1'b1;
                count_next = count_reg + 1'b1;
                if (count_reg == '1)
                begin
                    state_next = dmtt_pkg::ST_IDLE;
                end
            end
            dmtt_pkg::ST_IDLE:
            begin
                busy = 1'b0;
                if (start)
                begin
                    case (action)
                        dmtt_pkg::ACT_PROBE, dmtt_pkg::ACT_STORE:
                        begin
                            cmd.lookup = 1'b1;
                            state_next = dmtt_pkg::ST_ACCESS;
                        end
                        dmtt_pkg::ACT_CLEAR:
                        begin
                            count_next = '0;
                            state_next = dmtt_pkg::ST_CLEAR;
                        end
                        default:
                        begin
                            // drop unknown actions
                            state_next = dmtt_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            dmtt_pkg::ST_ACCESS:
            begin
                cmd.eval   = 1'b1;
                state_next = dmtt_pkg::ST_IDLE;
            end
            default:
            begin
                state_next = dmtt_pkg::ST_IDLE;
            end
        endcase
        // a size write wipes the table: hold off requests and restart the sweep
        if (cfg_write)
        begin
            busy       = 1'b1;
            cmd.lookup = 1'b0;
            count_next = '0;
            state_next = dmtt_pkg::ST_CLEAR;
        end
    end

endmodule

// ===== rtl/dmtt_datapath.sv =====
// Datapath: slot memory, size register, key compare, replacement decision
// and the result register. Depends on dmtt_pkg.
module dmtt_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  dmtt_pkg::cmd_t     cmd,
    input  dmtt_pkg::req_t     req,
    input  logic [4:0]         cfg_data,
    output logic               done,
    output dmtt_pkg::rsp_t     rsp
);

    dmtt_pkg::entry_t                 mem [dmtt_pkg::SLOT_COUNT];
    dmtt_pkg::entry_t                 rd_reg;
    dmtt_pkg::req_t                   req_reg;
    logic [dmtt_pkg::INDEX_BITS-1:0]  addr_reg;
    logic [4:0]                       size_reg;
    logic                             done_reg;
    dmtt_pkg::rsp_t                   rsp_reg;

    logic [4:0]                       eff_bits;
    logic [dmtt_pkg::INDEX_BITS-1:0]  index_mask;
    logic [dmtt_pkg::INDEX_BITS-1:0]  rd_addr;
    logic                             key_eq;
    logic                             match;
    logic                             replace;
    logic signed [15:0]               depth_sat;
    logic [31:0]                      move_in32;
    logic [31:0]                      move_out32;
    dmtt_pkg::entry_t                 new_entry;
    logic                             we;
    logic [dmtt_pkg::INDEX_BITS-1:0]  waddr;
    dmtt_pkg::entry_t                 wdata;

    // clamp size to the index width and build the slot mask
    always_comb
    begin
        if (size_reg > 5'(dmtt_pkg::INDEX_BITS))
        begin
            eff_bits = 5'(dmtt_pkg::INDEX_BITS);
        end
        else
        begin
            eff_bits = size_reg;
        end
        for (int i = 0; i < dmtt_pkg::INDEX_BITS; i++)
        begin
            index_mask[i] = (i < int'(eff_bits));
        end
    end

    assign rd_addr = req.key[dmtt_pkg::INDEX_BITS-1:0] & index_mask;

    assign key_eq  = (rd_reg.key == req_reg.key);
    assign match   = rd_reg.valid && key_eq;
    // compare the unclamped request depth against the stored depth
    assign replace = !rd_reg.valid || key_eq ||
                     (req_reg.depth >= 32'(rd_reg.depth));

    always_comb
    begin
        if (req_reg.depth < dmtt_pkg::DEPTH_MIN)
        begin
            depth_sat = dmtt_pkg::DEPTH_MIN[15:0];
        end
        else if (req_reg.depth > dmtt_pkg::DEPTH_MAX)
        begin
            depth_sat = dmtt_pkg::DEPTH_MAX[15:0];
        end
        else
        begin
            depth_sat = req_reg.depth[15:0];
        end
    end

    assign move_in32  = {16'b0, req_reg.move};
    assign move_out32 = 32'(rd_reg.move);

    always_comb
    begin
        new_entry.valid = 1'b1;
        new_entry.key   = req_reg.key;
        new_entry.depth = depth_sat;
        new_entry.score = req_reg.score;
        new_entry.bound = req_reg.bound;
        new_entry.move  = move_in32[dmtt_pkg::MOVE_BITS-1:0];
    end

    always_comb
    begin
        if (cmd.clr_we)
        begin
            we    = 1'b1;
            waddr = cmd.clr_addr;
            wdata = '0;
        end
        else
        begin
            we    = cmd.eval && (req_reg.action == dmtt_pkg::ACT_STORE) && replace;
            waddr = addr_reg;
            wdata = new_entry;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (cmd.lookup)
        begin
            rd_reg <= mem[rd_addr];
        end
    end

    // hold the request while the slot is read
    always_ff @(posedge clk)
    begin
        if (cmd.lookup)
        begin
            req_reg  <= req;
            addr_reg <= rd_addr;
        end
        if (cmd.eval)
        begin
            if (match)
            begin
                rsp_reg.hit       <= 1'b1;
                rsp_reg.hit_depth <= rd_reg.depth;
                rsp_reg.hit_score <= rd_reg.score;
                rsp_reg.hit_bound <= rd_reg.bound;
                rsp_reg.hit_move  <= move_out32[15:0];
            end
            else
            begin
                rsp_reg <= '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            size_reg <= dmtt_pkg::SIZE_LOG2_RESET;
            done_reg <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_we)
            begin
                size_reg <= cfg_data;
            end
            done_reg <= cmd.eval && (req_reg.action == dmtt_pkg::ACT_PROBE);
        end
    end

    assign done = done_reg;
    assign rsp  = rsp_reg;

endmodule

// ===== rtl/direct_mapped_transposition_table_core.sv =====
// Top level of the direct-mapped transposition table.
// Depends on dmtt_pkg, dmtt_ctrl and dmtt_datapath.
//
// Usage:
//   A request (probe, store or clear) is taken at a rising edge with start
//   high and busy low. A probe returns one result on rsp, marked by done for
//   exactly one cycle; store, clear and the unused action code return none.
//   The receiver cannot stall: rsp must be taken in the cycle done is high.
//   Probe and store each take a slot read, then a compare and optional
//   write-back of the slot, so a new request is taken only once the previous
//   one is through; the unused action code leaves busy low. A probe result is
//   on rsp in the cycle after the compare, the cycle in which the next
//   request may also be taken.
//   The size_log2 register is written through cfg_valid/cfg_ready/cfg_data;
//   cfg_ready is always high, and busy is high in any cycle with cfg_valid.
//   A write also wipes the table.
//   A clearing pass writes every one of the 2^16 slots, one per cycle,
//   holding busy high until the last slot is written. It runs after reset,
//   after a clear request and after every size write. size_log2 resets to 16.
module direct_mapped_transposition_table_core (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    output logic               busy,
    input  dmtt_pkg::req_t     req,
    output logic               done,
    output dmtt_pkg::rsp_t     rsp,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [4:0]         cfg_data
);

    dmtt_pkg::cmd_t cmd;
    logic           cfg_write;

    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;

    dmtt_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .action    (req.action),
        .cfg_write (cfg_write),
        .busy      (busy),
        .cmd       (cmd)
    );

    dmtt_datapath u_datapath (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .req      (req),
        .cfg_data (cfg_data),
        .done     (done),
        .rsp      (rsp)
    );

endmodule

// ===== bench/tb_direct_mapped_transposition_table_core.sv =====
// Self-checking bench for direct_mapped_transposition_table_core: probes, stores,
// clears and index-width writes, checked against an in-bench mirror of the table.
// Depends on dmtt_pkg and the core RTL only.
module tb_direct_mapped_transposition_table_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [1:0] ACT_UNUSED = 2'd3;

    localparam logic [1:0] BOUND_EXACT = 2'd0;
    localparam logic [1:0] BOUND_LOWER = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;
    localparam logic [1:0] BOUND_SPARE = 2'd3;

    // Mirror of the table contents; a present slot is a valid slot.
    class tt_mirror;
        logic [4:0]        size_log2;
        dmtt_pkg::entry_t  slots[int unsigned];
        dmtt_pkg::rsp_t    probe_results_q[$];
        int                errors;
        int                probes;
        int                hits;
        int                stores;
        int                replaced;
        int                clears;
        int                ignored;
        int                size_writes;

        function new();
            size_log2 = dmtt_pkg::SIZE_LOG2_RESET;
        endfunction

        function int pending();
            return probe_results_q.size();
        endfunction

        function void write_size(logic [4:0] value);
            size_log2 = value;
            slots.delete();
            size_writes++;
        endfunction

        function int unsigned slot_index(logic [63:0] key);
            int unsigned width;
            width = (size_log2 > dmtt_pkg::INDEX_BITS) ? dmtt_pkg::INDEX_BITS : size_log2;
            return key[31:0] & ((32'd1 << width) - 32'd1);
        endfunction

        function void note_request(dmtt_pkg::req_t r);
            int unsigned        idx;
            dmtt_pkg::rsp_t     want;
            dmtt_pkg::entry_t   ent;
            logic signed [31:0] d;
            logic signed [15:0] old_depth;
            bit                 replace;
            idx = slot_index(r.key);
            case (r.action)
                dmtt_pkg::ACT_PROBE:
                begin
                    want = '0;
                    if (slots.exists(idx) && slots[idx].key == r.key)
                    begin
                        want.hit       = 1'b1;
                        want.hit_depth = slots[idx].depth;
                        want.hit_score = slots[idx].score;
                        want.hit_bound = slots[idx].bound;
                        want.hit_move  = slots[idx].move;
                        hits++;
                    end
                    probe_results_q.push_back(want);
                    probes++;
                end
                dmtt_pkg::ACT_STORE:
                begin
                    stores++;
                    d = r.depth;
                    replace = !slots.exists(idx);
                    if (!replace)
                    begin
                        old_depth = slots[idx].depth;
                        // compare the raw 32-bit depth against the stored 16-bit one
                        replace = (slots[idx].key == r.key) || (d >= old_depth);
                    end
                    if (replace)
                    begin
                        ent.valid = 1'b1;
                        ent.key   = r.key;
                        if (d < dmtt_pkg::DEPTH_MIN)
                            ent.depth = dmtt_pkg::DEPTH_MIN[15:0];
                        else if (d > dmtt_pkg::DEPTH_MAX)
                            ent.depth = dmtt_pkg::DEPTH_MAX[15:0];
                        else
                            ent.depth = d[15:0];
                        ent.score = r.score;
                        ent.bound = r.bound;
                        ent.move  = r.move[dmtt_pkg::MOVE_BITS-1:0];
                        slots[idx] = ent;
                        replaced++;
                    end
                end
                dmtt_pkg::ACT_CLEAR:
                begin
                    slots.delete();
                    clears++;
                end
                default: ignored++;
            endcase
        endfunction

        function void compare_field(string name, logic [31:0] want, logic [31:0] got);
            if (got !== want)
            begin
                $error("%s mismatch: expected %0h, actual %0h", name, want, got);
                errors++;
            end
        endfunction

        function void check_probe_result(dmtt_pkg::rsp_t got);
            dmtt_pkg::rsp_t want;
            if (probe_results_q.size() == 0)
            begin
                $error("probe result with none outstanding: hit=%0b", got.hit);
                errors++;
                return;
            end
            want = probe_results_q.pop_front();
            compare_field("hit", want.hit, got.hit);
            compare_field("hit_depth", want.hit_depth, got.hit_depth);
            compare_field("hit_score", want.hit_score, got.hit_score);
            compare_field("hit_bound", want.hit_bound, got.hit_bound);
            compare_field("hit_move", want.hit_move, got.hit_move);
        endfunction
    endclass

    logic           clk = 1'b0;
    logic           rst_n = 1'b0;
    logic           start = 1'b0;
    logic           busy;
    dmtt_pkg::req_t req = '0;
    logic           done;
    dmtt_pkg::rsp_t rsp;
    logic           cfg_valid = 1'b0;
    logic           cfg_ready;
    logic [4:0]     cfg_data = '0;

    tt_mirror tt = new();
    int       idle_pct = 32;

    direct_mapped_transposition_table_core u_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .busy      (busy),
        .req       (req),
        .done      (done),
        .rsp       (rsp),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_valid && cfg_ready)
                tt.write_size(cfg_data);
            if (start && !busy)
                tt.note_request(req);
            if (done)
                tt.check_probe_result(rsp);
        end
    end

    function automatic dmtt_pkg::req_t make_req(logic [1:0] action, logic [63:0] key,
                                                logic signed [31:0] depth,
                                                logic signed [31:0] score,
                                                logic [1:0] bound, logic [15:0] move);
        dmtt_pkg::req_t r;
        r.action = action;
        r.key    = key;
        r.depth  = depth;
        r.score  = score;
        r.bound  = bound;
        r.move   = move;
        return r;
    endfunction

    task automatic send(input dmtt_pkg::req_t r);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start <= 1'b1;
        req   <= r;
        do @(posedge clk); while (busy);
    endtask

    // Hold off new requests until every probe result is back.
    task automatic drain();
        start <= 1'b0;
        do @(posedge clk); while (tt.pending() != 0);
    endtask

    task automatic write_size(input logic [4:0] value);
        drain();
        // a store may still be finishing its write-back
        repeat (4) @(posedge clk);
        while (busy) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial
    begin
        int unsigned        phase_size[6];
        int unsigned        phase_idle[6];
        logic signed [31:0] extreme_depths[6];
        logic [31:0]        key_lo[8];
        logic [31:0]        key_hi[4];
        logic [63:0]        last_key;
        logic [63:0]        key;
        logic [1:0]         action;
        logic signed [31:0] depth;
        dmtt_pkg::req_t     r;
        int                 n;
        int                 clear_at;
        int unsigned        roll;

        phase_size     = '{0, 31, 4, 16, 9, 1};
        phase_idle     = '{32, 32, 67, 67, 0, 0};
        extreme_depths = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sd32767,
                           32'sd32768, -32'sd32768, -32'sd32769};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed: saturation, replacement rules, ignored code, clear
        send(make_req(dmtt_pkg::ACT_PROBE, 64'h0, 0, 0, BOUND_EXACT, 16'h0));
        send(make_req(dmtt_pkg::ACT_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 32'sh7FFF_FFFF,
                      32'sh8000_0000, BOUND_SPARE, 16'hFFFF));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, BOUND_EXACT, 16'h0));
        send(make_req(dmtt_pkg::ACT_STORE, 64'h0, 32'sh8000_0000, 32'sh7FFF_FFFF,
                      BOUND_EXACT, 16'h0));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'h0, 0, 0, BOUND_EXACT, 16'h0));
        // shallower than the clamped stored depth: slot keeps the old key
        send(make_req(dmtt_pkg::ACT_STORE, 64'h1_0000_0000, -32'sd40000, 32'sd7,
                      BOUND_LOWER, 16'h1234));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'h1_0000_0000, 0, 0, BOUND_EXACT, 16'h0));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'h0, 0, 0, BOUND_EXACT, 16'h0));
        // equal depth replaces
        send(make_req(dmtt_pkg::ACT_STORE, 64'h1_0000_0000, -32'sd32768, -32'sd7,
                      BOUND_UPPER, 16'h4321));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'h1_0000_0000, 0, 0, BOUND_EXACT, 16'h0));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'h0, 0, 0, BOUND_EXACT, 16'h0));
        // same key replaces even when shallower
        send(make_req(dmtt_pkg::ACT_STORE, 64'hFFFF_FFFF_FFFF_FFFF, 32'sd5, 32'sd99,
                      BOUND_LOWER, 16'hA5A5));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, BOUND_EXACT, 16'h0));
        send(make_req(dmtt_pkg::ACT_STORE, 64'h0123_4567_89AB_FFFF, 32'sd4, 32'sd1,
                      BOUND_UPPER, 16'h00FF));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'h0123_4567_89AB_FFFF, 0, 0, BOUND_EXACT, 16'h0));
        send(make_req(dmtt_pkg::ACT_STORE, 64'h0123_4567_89AB_FFFF, 32'sd5, 32'sd2,
                      BOUND_UPPER, 16'hFF00));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'h0123_4567_89AB_FFFF, 0, 0, BOUND_EXACT, 16'h0));
        send(make_req(ACT_UNUSED, 64'h0123_4567_89AB_FFFF, 32'sh7FFF_FFFF, 32'sd3,
                      BOUND_EXACT, 16'h0));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'h0123_4567_89AB_FFFF, 0, 0, BOUND_EXACT, 16'h0));
        send(make_req(dmtt_pkg::ACT_STORE, 64'h5555_5555_5555_5555, 32'sd100000, -32'sd1,
                      BOUND_LOWER, 16'h5A5A));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'h5555_5555_5555_5555, 0, 0, BOUND_EXACT, 16'h0));
        send(make_req(dmtt_pkg::ACT_CLEAR, 64'hAAAA_AAAA_AAAA_AAAA, 0, 0, BOUND_EXACT, 16'h0));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'h5555_5555_5555_5555, 0, 0, BOUND_EXACT, 16'h0));
        send(make_req(dmtt_pkg::ACT_PROBE, 64'h0123_4567_89AB_FFFF, 0, 0, BOUND_EXACT, 16'h0));

        for (int p = 0; p < 6; p++)
        begin
            write_size(phase_size[p][4:0]);
            idle_pct = phase_idle[p];
            foreach (key_lo[i]) key_lo[i] = $urandom;
            foreach (key_hi[i]) key_hi[i] = $urandom;
            last_key = {key_hi[0], key_lo[0]};
            clear_at = (p % 2 == 1) ? int'($urandom_range(20, 170)) : -1;
            n = 0;
            while (n < 175)
            begin
                roll = $urandom_range(0, 99);
                if (n == clear_at)
                    action = dmtt_pkg::ACT_CLEAR;
                else if (roll < 45)
                    action = dmtt_pkg::ACT_PROBE;
                else if (roll < 92)
                    action = dmtt_pkg::ACT_STORE;
                else
                    action = ACT_UNUSED;

                // mostly keys from a small pool so slots collide and probes hit
                if ($urandom_range(0, 9) == 0)
                    key = {$urandom, $urandom};
                else if (action == dmtt_pkg::ACT_PROBE && $urandom_range(0, 2) == 0)
                    key = last_key;
                else
                    key = {key_hi[$urandom_range(0, 3)], key_lo[$urandom_range(0, 7)]};
                if (action == dmtt_pkg::ACT_STORE)
                    last_key = key;

                case ($urandom_range(0, 9))
                    0:       depth = $urandom;
                    1:       depth = extreme_depths[$urandom_range(0, 5)];
                    default: depth = int'($urandom_range(0, 40)) - 20;
                endcase

                r = make_req(action, key, depth, $urandom, 2'($urandom_range(0, 3)),
                             16'($urandom_range(0, 65535)));
                send(r);
                if (action != ACT_UNUSED)
                begin
                    n++;
                    if (n % 64 == 0)
                        drain();
                end
            end
        end

        drain();
        repeat (8) @(posedge clk);

        if (tt.pending() != 0)
        begin
            $error("%0d probe results never arrived", tt.pending());
            tt.errors++;
        end
        $display("Run covered %0d probes (%0d hits), %0d stores (%0d written), %0d clears,",
                 tt.probes, tt.hits, tt.stores, tt.replaced, tt.clears);
        $display("%0d ignored requests and %0d index-width writes from 0 up to 31.",
                 tt.ignored, tt.size_writes);
        if (tt.errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/dmtt_pkg.sv
rtl/dmtt_ctrl.sv
rtl/dmtt_datapath.sv
rtl/direct_mapped_transposition_table_core.sv
bench/tb_direct_mapped_transposition_table_core.sv
